### rtl/packet_rule_filter_assert.svh
// Assertion macros shared by the packet rule filter RTL.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef PACKET_RULE_FILTER_ASSERT_SVH
`define PACKET_RULE_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prf_pkg.sv
// Shared types and constants of the packet rule filter.
// No dependencies.
package prf_pkg;

  localparam int unsigned RULE_DEPTH = 64;

  // Operation codes.
  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;

  // Rule classes.
  localparam logic [1:0] CLS_IP   = 2'd0;
  localparam logic [1:0] CLS_TCP  = 2'd1;
  localparam logic [1:0] CLS_UDP  = 2'd2;
  localparam logic [1:0] CLS_ICMP = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // IPv4 protocol numbers.
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // One stored rule.
  typedef struct packed {
    logic [31:0] id;
    logic        deny;
    logic [1:0]  cls;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ptr_load;
    logic ptr_dec;
    logic ptr_inc;
    logic rd_dec;
    logic rd_inc;
    logic wr_add;
    logic wr_shift;
    logic cnt_dec;
    logic phase_set;
    logic res_hit;
    logic st_full;
    logic st_nf;
  } prf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       ipv4;
    logic       full;
    logic       ptr_zero;
    logic       cls_valid;
    logic       phase;
    logic       match;
    logic       id_eq;
    logic       shift_end;
  } prf_sts_t;

endpackage

### rtl/prf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prf_controller.sv
// Sequencing state machine of the packet rule filter.
// Depends on prf_pkg and packet_rule_filter_assert.svh.
`include "packet_rule_filter_assert.svh"

module prf_controller import prf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  input  prf_sts_t sts_i,
  output prf_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_CMP  = 3'd4;
  localparam logic [2:0] S_SHF_RD   = 3'd5;
  localparam logic [2:0] S_SHF_WR   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DONE;
          case (sts_i.op)
            OP_CLASSIFY: begin
              if (sts_i.ipv4) begin
                cmd_o.ptr_load = 1'b1;
                state_d        = S_SCAN_RD;
              end
            end
            OP_ADD: begin
              if (sts_i.full) begin
                cmd_o.st_full = 1'b1;
              end else begin
                cmd_o.wr_add = 1'b1;
              end
            end
            OP_DELETE: begin
              cmd_o.ptr_load = 1'b1;
              state_d        = S_DEL_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts_i.ptr_zero) begin
          // End of the address pass: move on to the protocol class or finish.
          if (!sts_i.phase && sts_i.cls_valid) begin
            cmd_o.phase_set = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cmd_o.rd_dec  = 1'b1;
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_DEL_RD: begin
        if (sts_i.ptr_zero) begin
          cmd_o.st_nf = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.rd_dec  = 1'b1;
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        state_d = sts_i.id_eq ? S_SHF_RD : S_DEL_RD;
      end
      S_SHF_RD: begin
        if (sts_i.shift_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_inc = 1'b1;
          state_d      = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = S_SHF_RD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  `PRF_ASSERT_NXT(a_done_single, done_o, !done_o, "result strobe lasted more than one cycle")
  `PRF_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted request did not raise busy")
  `PRF_ASSERT_IMP(a_done_busy, done_o, busy_o, "result strobe outside a request")
  `PRF_ASSERT_IMP(a_one_write, cmd_o.wr_add, !cmd_o.wr_shift, "two table writes in one cycle")

endmodule

### rtl/prf_datapath.sv
// Rule table, request registers, match logic and result registers.
// Depends on prf_pkg and prf_ram.
module prf_datapath import prf_pkg::*; #(
  parameter int unsigned DEPTH = RULE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  operation_i,
  input  logic [31:0] rule_id_i,
  input  logic        rule_deny_i,
  input  logic [1:0]  rule_class_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic        is_ipv4_i,
  input  prf_cmd_t    cmd_i,
  output prf_sts_t    sts_o,
  output logic        verdict_drop_o,
  output logic        rule_hit_o,
  output logic [31:0] hit_rule_id_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0] id_q, src_q, dst_q;
  logic [15:0] sport_q, dport_q;
  logic [7:0]  proto_q;
  logic        phase_q;
  logic [CW-1:0] ptr_q, cnt_q, ptr_dec, ptr_inc;
  logic        drop_q, hit_q;
  logic [31:0] hid_q;
  logic [1:0]  status_q;

  entry_t      rdata, wdata, add_entry;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]  sel_cls, cmp_cls;
  logic        cls_valid, is_icmp;
  logic [15:0] pk_sport, pk_dport;

  assign ptr_dec = ptr_q - CW'(1);
  assign ptr_inc = ptr_q + CW'(1);

  // Rule table storage.
  assign add_entry = '{id: rule_id_i, deny: rule_deny_i, cls: rule_class_i,
                       src: source_address_i, dst: dest_address_i,
                       sport: source_port_i, dport: dest_port_i};
  assign wdata = cmd_i.wr_add ? add_entry : rdata;
  assign waddr = cmd_i.wr_add ? cnt_q[AW-1:0] : ptr_q[AW-1:0];
  assign raddr = cmd_i.rd_inc ? ptr_inc[AW-1:0] : ptr_dec[AW-1:0];

  prf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_add | cmd_i.wr_shift),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_dec | cmd_i.rd_inc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= rule_id_i;
      src_q   <= source_address_i;
      dst_q   <= dest_address_i;
      sport_q <= source_port_i;
      dport_q <= dest_port_i;
      proto_q <= ip_protocol_i;
    end
  end

  // Fill count, search pointer and search phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ptr_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cmd_i.wr_add) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.ptr_load || cmd_i.phase_set) begin
        ptr_q <= cnt_q;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_dec;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_inc;
      end
      if (cmd_i.load) begin
        phase_q <= 1'b0;
      end else if (cmd_i.phase_set) begin
        phase_q <= 1'b1;
      end
    end
  end

  // Protocol to class mapping; ICMP packets compare with zero ports.
  always_comb begin
    sel_cls   = CLS_IP;
    cls_valid = 1'b1;
    case (proto_q)
      PROTO_UDP:  sel_cls = CLS_UDP;
      PROTO_TCP:  sel_cls = CLS_TCP;
      PROTO_ICMP: sel_cls = CLS_ICMP;
      default:    cls_valid = 1'b0;
    endcase
  end

  assign is_icmp  = (sel_cls == CLS_ICMP);
  assign pk_sport = is_icmp ? 16'd0 : sport_q;
  assign pk_dport = is_icmp ? 16'd0 : dport_q;
  assign cmp_cls  = phase_q ? sel_cls : CLS_IP;

  // Status toward the controller.
  assign sts_o.op        = operation_i;
  assign sts_o.ipv4      = is_ipv4_i;
  assign sts_o.full      = (cnt_q == CW'(DEPTH));
  assign sts_o.ptr_zero  = (ptr_q == '0);
  assign sts_o.cls_valid = cls_valid;
  assign sts_o.phase     = phase_q;
  assign sts_o.match     = (rdata.cls == cmp_cls)
                         && (rdata.src == '0 || rdata.src == src_q)
                         && (rdata.dst == '0 || rdata.dst == dst_q)
                         && (!phase_q
                             || ((rdata.sport == '0 || rdata.sport == pk_sport)
                              && (rdata.dport == '0 || rdata.dport == pk_dport)));
  assign sts_o.id_eq     = (rdata.id == id_q);
  assign sts_o.shift_end = (ptr_inc >= cnt_q);

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      drop_q   <= 1'b0;
      hit_q    <= 1'b0;
      hid_q    <= '0;
      status_q <= ST_OK;
    end else if (cmd_i.res_hit) begin
      drop_q <= rdata.deny;
      hit_q  <= 1'b1;
      hid_q  <= rdata.id;
    end
    if (cmd_i.st_full) begin
      status_q <= ST_FULL;
    end else if (cmd_i.st_nf) begin
      status_q <= ST_NOT_FOUND;
    end
  end

  assign verdict_drop_o = drop_q;
  assign rule_hit_o     = hit_q;
  assign hit_rule_id_o  = hid_q;
  assign status_o       = status_q;

endmodule

### rtl/packet_rule_filter.sv
// Top level of the packet rule filter: controller plus datapath.
// Depends on prf_pkg, prf_controller, prf_datapath and prf_ram.
//
//  Channel   Handshake            Fields
//  request   start_i / busy_o     operation_i .. is_ipv4_i
//  result    done_o (strobe)      verdict_drop_o, rule_hit_o, hit_rule_id_o, status_o
//
// One request at a time; busy_o stays high from acceptance through the result strobe.
// Add and op code 3 go straight to the result; classify makes up to two newest-first
// passes over the stored rules, the second only for a known protocol class.
// Delete makes a newest-first search for the id, then the newer entries slide down
// one slot each to close the gap.
// Reset empties the table at once; no clearing pass. The result cannot be stalled.
module packet_rule_filter import prf_pkg::*; #(
  parameter int unsigned RULE_DEPTH_P = RULE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] rule_id_i,
  input  logic        rule_deny_i,
  input  logic [1:0]  rule_class_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic        is_ipv4_i,
  output logic        done_o,
  output logic        verdict_drop_o,
  output logic        rule_hit_o,
  output logic [31:0] hit_rule_id_o,
  output logic [1:0]  status_o
);

  prf_cmd_t cmd;
  prf_sts_t sts;

  // Sequencer.
  prf_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Rule table and compare logic.
  prf_datapath #(
    .DEPTH (RULE_DEPTH_P)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .rule_id_i        (rule_id_i),
    .rule_deny_i      (rule_deny_i),
    .rule_class_i     (rule_class_i),
    .source_address_i (source_address_i),
    .dest_address_i   (dest_address_i),
    .source_port_i    (source_port_i),
    .dest_port_i      (dest_port_i),
    .ip_protocol_i    (ip_protocol_i),
    .is_ipv4_i        (is_ipv4_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .verdict_drop_o   (verdict_drop_o),
    .rule_hit_o       (rule_hit_o),
    .hit_rule_id_o    (hit_rule_id_o),
    .status_o         (status_o)
  );

endmodule
